/* hdl/bilinear_gray_image_scaler_assert.svh */
// Assertion macros for the bilinear grayscale scaler.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef BILINEAR_GRAY_IMAGE_SCALER_ASSERT_SVH
`define BILINEAR_GRAY_IMAGE_SCALER_ASSERT_SVH
`ifndef SYNTHESIS
`define BGIS_ASSERT_IMPLY(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed: %m");
`define BGIS_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed: %m");
`else
`define BGIS_ASSERT_IMPLY(label, pre, post)
`define BGIS_ASSERT_NEXT(label, pre, post)
`endif
`endif

/* hdl/bgis_pkg.sv */
`default_nettype none
package bgis_pkg;
	localparam int DEF_MAX_WIDTH = 256;
	localparam int DEF_MAX_HEIGHT = 256;
	localparam int DEF_WEIGHT_BITS = 8;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS = 24;
	localparam int SIZE_BITS = 9;
	localparam int STEP_BITS = 24;
	localparam int COORD_BITS = 8;
	localparam int PIXEL_BITS = 8;
	localparam int FRAC_BITS = 16;

	localparam int QUEUE_DEPTH = 2;
	localparam int OUT_DEPTH = 4;

	localparam logic [SIZE_BITS-1:0] SIZE_RESET = 9'd256;
	localparam logic [STEP_BITS-1:0] STEP_RESET = 24'h010000;

	localparam logic OP_WRITE = 1'b0;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_SOURCE_WIDTH = 3'd0,
		REG_SOURCE_HEIGHT = 3'd1,
		REG_TARGET_WIDTH = 3'd2,
		REG_TARGET_HEIGHT = 3'd3,
		REG_HORIZONTAL_STEP = 3'd4,
		REG_VERTICAL_STEP = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_FLAG = 2'd1,
		CMD_BLEND = 2'd2
	} cmd_kind_t;
endpackage
`default_nettype wire

/* hdl/bgis_ifs.sv */
`default_nettype none
interface bgis_req_if;
	logic valid;
	logic ready;
	logic opcode;
	logic [bgis_pkg::COORD_BITS-1:0] column_pos;
	logic [bgis_pkg::COORD_BITS-1:0] row_pos;
	logic [bgis_pkg::PIXEL_BITS-1:0] pixel_in;
	modport source (output valid, opcode, column_pos, row_pos, pixel_in, input ready);
	modport sink (input valid, opcode, column_pos, row_pos, pixel_in, output ready);
endinterface

interface bgis_rsp_if;
	logic valid;
	logic ready;
	logic [bgis_pkg::PIXEL_BITS-1:0] pixel_out;
	logic out_of_range;
	modport source (output valid, pixel_out, out_of_range, input ready);
	modport sink (input valid, pixel_out, out_of_range, output ready);
endinterface

interface bgis_cfg_if;
	logic valid;
	logic ready;
	logic [bgis_pkg::CFG_INDEX_BITS-1:0] index;
	logic [bgis_pkg::CFG_DATA_BITS-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

interface bgis_cmd_if #(
	parameter int MAX_WIDTH = bgis_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bgis_pkg::DEF_MAX_HEIGHT,
	parameter int WEIGHT_BITS = bgis_pkg::DEF_WEIGHT_BITS
);
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	logic valid;
	logic ready;
	bgis_pkg::cmd_kind_t kind;
	logic [XW-1:0] x0;
	logic [XW-1:0] x1;
	logic [YW-1:0] y0;
	logic [YW-1:0] y1;
	logic [WEIGHT_BITS-1:0] fx;
	logic [WEIGHT_BITS-1:0] fy;
	logic [bgis_pkg::PIXEL_BITS-1:0] pixel;
	modport source (output valid, kind, x0, x1, y0, y1, fx, fy, pixel, input ready);
	modport sink (input valid, kind, x0, x1, y0, y1, fx, fy, pixel, output ready);
endinterface
`default_nettype wire

/* hdl/bgis_front.sv */
`default_nettype none
module bgis_front #(
	parameter int MAX_WIDTH = bgis_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bgis_pkg::DEF_MAX_HEIGHT,
	parameter int WEIGHT_BITS = bgis_pkg::DEF_WEIGHT_BITS
) (
	input logic clk,
	input logic arst_n,
	bgis_req_if.sink req,
	bgis_cfg_if.sink cfg,
	bgis_cmd_if.source cmd
);
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int WB = WEIGHT_BITS;
	localparam int PW = bgis_pkg::COORD_BITS + bgis_pkg::STEP_BITS;
	localparam int FB = bgis_pkg::FRAC_BITS;

	logic [bgis_pkg::SIZE_BITS-1:0] source_width_q;
	logic [bgis_pkg::SIZE_BITS-1:0] source_height_q;
	logic [bgis_pkg::SIZE_BITS-1:0] target_width_q;
	logic [bgis_pkg::SIZE_BITS-1:0] target_height_q;
	logic [bgis_pkg::STEP_BITS-1:0] horizontal_step_q;
	logic [bgis_pkg::STEP_BITS-1:0] vertical_step_q;

	logic valid_s1;
	logic op_s1;
	logic flag_s1;
	logic keep_s1;
	logic [bgis_pkg::COORD_BITS-1:0] col_s1;
	logic [bgis_pkg::COORD_BITS-1:0] row_s1;
	logic [bgis_pkg::PIXEL_BITS-1:0] pixel_s1;
	logic [PW-1:0] sx_s1;
	logic [PW-1:0] sy_s1;

	logic advance;
	logic [PW-1:0] sx_d;
	logic [PW-1:0] sy_d;
	logic flag_d;
	logic keep_d;
	logic [31:0] sw;
	logic [31:0] sh;
	logic [31:0] x0w;
	logic [31:0] x1w;
	logic [31:0] y0w;
	logic [31:0] y1w;

	function automatic logic [31:0] limit_size(input logic [bgis_pkg::SIZE_BITS-1:0] v,
			input logic [31:0] maxv);
		logic [31:0] r;
		if (v == '0) begin
			r = 32'd1;
		end else if (32'(v) > maxv) begin
			r = maxv;
		end else begin
			r = 32'(v);
		end
		return r;
	endfunction

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_width_q <= bgis_pkg::SIZE_RESET;
			source_height_q <= bgis_pkg::SIZE_RESET;
			target_width_q <= bgis_pkg::SIZE_RESET;
			target_height_q <= bgis_pkg::SIZE_RESET;
			horizontal_step_q <= bgis_pkg::STEP_RESET;
			vertical_step_q <= bgis_pkg::STEP_RESET;
		end else if (cfg.valid) begin
			unique case (bgis_pkg::cfg_reg_t'(cfg.index))
				bgis_pkg::REG_SOURCE_WIDTH: source_width_q <= cfg.data[bgis_pkg::SIZE_BITS-1:0];
				bgis_pkg::REG_SOURCE_HEIGHT: source_height_q <= cfg.data[bgis_pkg::SIZE_BITS-1:0];
				bgis_pkg::REG_TARGET_WIDTH: target_width_q <= cfg.data[bgis_pkg::SIZE_BITS-1:0];
				bgis_pkg::REG_TARGET_HEIGHT: target_height_q <= cfg.data[bgis_pkg::SIZE_BITS-1:0];
				bgis_pkg::REG_HORIZONTAL_STEP: horizontal_step_q <= cfg.data;
				bgis_pkg::REG_VERTICAL_STEP: vertical_step_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign advance = !valid_s1 || cmd.ready || !keep_s1;
	assign req.ready = advance;

	assign sx_d = PW'(req.column_pos) * PW'(horizontal_step_q);
	assign sy_d = PW'(req.row_pos) * PW'(vertical_step_q);
	assign flag_d = ({1'b0, req.column_pos} >= target_width_q)
		|| ({1'b0, req.row_pos} >= target_height_q);
	assign keep_d = (req.opcode != bgis_pkg::OP_WRITE)
		|| ((32'(req.column_pos) < 32'(MAX_WIDTH)) && (32'(req.row_pos) < 32'(MAX_HEIGHT)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && advance) begin
			op_s1 <= req.opcode;
			col_s1 <= req.column_pos;
			row_s1 <= req.row_pos;
			pixel_s1 <= req.pixel_in;
			sx_s1 <= sx_d;
			sy_s1 <= sy_d;
			flag_s1 <= flag_d;
			keep_s1 <= keep_d;
		end
	end

	// clamp the top-left neighbor and its right and lower partners to the source edge
	always_comb begin
		sw = limit_size(source_width_q, 32'(MAX_WIDTH));
		sh = limit_size(source_height_q, 32'(MAX_HEIGHT));
		x0w = 32'(sx_s1[PW-1:FB]);
		y0w = 32'(sy_s1[PW-1:FB]);
		if (x0w >= sw) begin
			x0w = sw - 32'd1;
		end
		if (y0w >= sh) begin
			y0w = sh - 32'd1;
		end
		x1w = (x0w + 32'd1 < sw) ? x0w + 32'd1 : x0w;
		y1w = (y0w + 32'd1 < sh) ? y0w + 32'd1 : y0w;
	end

	assign cmd.valid = valid_s1 && keep_s1;
	assign cmd.kind = (op_s1 == bgis_pkg::OP_WRITE) ? bgis_pkg::CMD_WRITE
		: (flag_s1 ? bgis_pkg::CMD_FLAG : bgis_pkg::CMD_BLEND);
	assign cmd.x0 = (op_s1 == bgis_pkg::OP_WRITE) ? XW'(col_s1) : XW'(x0w);
	assign cmd.y0 = (op_s1 == bgis_pkg::OP_WRITE) ? YW'(row_s1) : YW'(y0w);
	assign cmd.x1 = XW'(x1w);
	assign cmd.y1 = YW'(y1w);
	assign cmd.fx = sx_s1[FB-1 -: WB];
	assign cmd.fy = sy_s1[FB-1 -: WB];
	assign cmd.pixel = pixel_s1;
endmodule
`default_nettype wire

/* hdl/bgis_queue.sv */
`default_nettype none
module bgis_queue #(
	parameter int MAX_WIDTH = bgis_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bgis_pkg::DEF_MAX_HEIGHT,
	parameter int WEIGHT_BITS = bgis_pkg::DEF_WEIGHT_BITS
) (
	input logic clk,
	input logic arst_n,
	bgis_cmd_if.sink head,
	bgis_cmd_if.source tail
);
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int KW = $bits(bgis_pkg::cmd_kind_t);
	localparam int EW = KW + 2 * XW + 2 * YW + 2 * WEIGHT_BITS + bgis_pkg::PIXEL_BITS;
	localparam int PTRW = (bgis_pkg::QUEUE_DEPTH > 1) ? $clog2(bgis_pkg::QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(bgis_pkg::QUEUE_DEPTH + 1);

	logic [EW-1:0] mem_q [bgis_pkg::QUEUE_DEPTH];
	logic [PTRW-1:0] wr_ptr_q;
	logic [PTRW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic [EW-1:0] entry_in;
	logic [EW-1:0] entry_out;
	logic [KW-1:0] kind_bits;
	logic push;
	logic pop;

	assign head.ready = count_q != CW'(bgis_pkg::QUEUE_DEPTH);
	assign tail.valid = count_q != '0;
	assign push = head.valid && head.ready;
	assign pop = tail.valid && tail.ready;

	assign entry_in = {head.kind, head.x0, head.x1, head.y0, head.y1, head.fx, head.fy,
		head.pixel};
	assign entry_out = mem_q[rd_ptr_q];
	assign {kind_bits, tail.x0, tail.x1, tail.y0, tail.y1, tail.fx, tail.fy, tail.pixel} =
		entry_out;
	assign tail.kind = bgis_pkg::cmd_kind_t'(kind_bits);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= entry_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTRW'(bgis_pkg::QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTRW'(bgis_pkg::QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

/* hdl/bgis_back.sv */
`default_nettype none
module bgis_back #(
	parameter int MAX_WIDTH = bgis_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bgis_pkg::DEF_MAX_HEIGHT,
	parameter int WEIGHT_BITS = bgis_pkg::DEF_WEIGHT_BITS
) (
	input logic clk,
	input logic arst_n,
	bgis_cmd_if.sink cmd,
	bgis_rsp_if.source rsp
);
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int WB = WEIGHT_BITS;
	localparam int PB = bgis_pkg::PIXEL_BITS;
	localparam int BANK_ROWS = (MAX_HEIGHT + 1) / 2;
	localparam int HW = (BANK_ROWS > 1) ? $clog2(BANK_ROWS) : 1;
	localparam int AW = HW + XW;
	localparam int BANK_DEPTH = 1 << AW;
	localparam int HSW = PB + WB;
	localparam int VSW = PB + 2 * WB;
	localparam int OPW = (bgis_pkg::OUT_DEPTH > 1) ? $clog2(bgis_pkg::OUT_DEPTH) : 1;
	localparam int OCW = $clog2(bgis_pkg::OUT_DEPTH + 1);
	localparam logic [WB:0] WEIGHT_ONE = {1'b1, {WB{1'b0}}};

	typedef enum logic [1:0] {
		ST_FIRST = 2'b01,
		ST_SECOND = 2'b10
	} seq_state_t;

	seq_state_t state_q;
	seq_state_t state_d;

	logic [PB-1:0] mem_even_q [BANK_DEPTH];
	logic [PB-1:0] mem_odd_q [BANK_DEPTH];
	logic [PB-1:0] even_data_q;
	logic [PB-1:0] odd_data_q;

	logic mem_we;
	logic launch;
	logic flag_launch;
	logic credit_ok;
	logic [XW-1:0] rd_col;
	logic [YW-1:0] row_even;
	logic [YW-1:0] row_odd;
	logic [AW-1:0] addr_even;
	logic [AW-1:0] addr_odd;
	logic [AW-1:0] addr_wr;

	logic valid_s1;
	logic flag_s1;
	logic odd_top_s1;
	logic same_row_s1;
	logic [WB-1:0] fx_s1;
	logic [WB-1:0] fy_s1;
	logic [PB-1:0] hold_even_s1;
	logic [PB-1:0] hold_odd_s1;

	logic [PB-1:0] p00;
	logic [PB-1:0] p01;
	logic [PB-1:0] p10;
	logic [PB-1:0] p11;
	logic [WB:0] wfx;
	logic [HSW:0] top_sum;
	logic [HSW:0] bottom_sum;

	logic valid_s2;
	logic flag_s2;
	logic [WB-1:0] fy_s2;
	logic [HSW-1:0] top_s2;
	logic [HSW-1:0] bottom_s2;

	logic [WB:0] wfy;
	logic [VSW:0] vert_sum;
	logic [PB-1:0] blend_pixel;

	logic [PB-1:0] fifo_pix_q [bgis_pkg::OUT_DEPTH];
	logic fifo_flag_q [bgis_pkg::OUT_DEPTH];
	logic [OPW-1:0] wr_ptr_q;
	logic [OPW-1:0] rd_ptr_q;
	logic [OCW-1:0] count_q;
	logic [OCW-1:0] inflight_q;
	logic pop;

	assign credit_ok = inflight_q < OCW'(bgis_pkg::OUT_DEPTH);

	always_comb begin
		state_d = state_q;
		cmd.ready = 1'b0;
		mem_we = 1'b0;
		launch = 1'b0;
		flag_launch = 1'b0;
		unique case (state_q)
			ST_FIRST: begin
				if (cmd.valid) begin
					unique case (cmd.kind)
						bgis_pkg::CMD_WRITE: begin
							mem_we = 1'b1;
							cmd.ready = 1'b1;
						end
						bgis_pkg::CMD_FLAG: begin
							if (credit_ok) begin
								cmd.ready = 1'b1;
								launch = 1'b1;
								flag_launch = 1'b1;
							end
						end
						bgis_pkg::CMD_BLEND: begin
							if (credit_ok) begin
								state_d = ST_SECOND;
							end
						end
						default: ;
					endcase
				end
			end
			ST_SECOND: begin
				cmd.ready = 1'b1;
				launch = 1'b1;
				state_d = ST_FIRST;
			end
			default: state_d = ST_FIRST;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FIRST;
		end else begin
			state_q <= state_d;
		end
	end

	// rows y0 and y0+1 sit in opposite banks, so one column of both rows is read per cycle
	assign rd_col = (state_q == ST_SECOND) ? cmd.x1 : cmd.x0;
	assign row_even = cmd.y0[0] ? cmd.y1 : cmd.y0;
	assign row_odd = cmd.y0[0] ? cmd.y0 : cmd.y1;
	assign addr_even = {HW'(row_even >> 1), rd_col};
	assign addr_odd = {HW'(row_odd >> 1), rd_col};
	assign addr_wr = {HW'(cmd.y0 >> 1), cmd.x0};

	always_ff @(posedge clk) begin
		if (mem_we && !cmd.y0[0]) begin
			mem_even_q[addr_wr] <= cmd.pixel;
		end
		even_data_q <= mem_even_q[addr_even];
	end

	always_ff @(posedge clk) begin
		if (mem_we && cmd.y0[0]) begin
			mem_odd_q[addr_wr] <= cmd.pixel;
		end
		odd_data_q <= mem_odd_q[addr_odd];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= launch;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (launch) begin
			flag_s1 <= flag_launch;
			fx_s1 <= cmd.fx;
			fy_s1 <= cmd.fy;
			odd_top_s1 <= cmd.y0[0];
			same_row_s1 <= cmd.y1 == cmd.y0;
			hold_even_s1 <= even_data_q;
			hold_odd_s1 <= odd_data_q;
		end
	end

	// hold regs carry the left column, the bank data regs the right column
	assign p00 = odd_top_s1 ? hold_odd_s1 : hold_even_s1;
	assign p01 = odd_top_s1 ? odd_data_q : even_data_q;
	assign p10 = same_row_s1 ? p00 : (odd_top_s1 ? hold_even_s1 : hold_odd_s1);
	assign p11 = same_row_s1 ? p01 : (odd_top_s1 ? even_data_q : odd_data_q);
	assign wfx = WEIGHT_ONE - {1'b0, fx_s1};
	assign top_sum = (HSW+1)'(p00) * (HSW+1)'(wfx) + (HSW+1)'(p01) * (HSW+1)'(fx_s1);
	assign bottom_sum = (HSW+1)'(p10) * (HSW+1)'(wfx) + (HSW+1)'(p11) * (HSW+1)'(fx_s1);

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			flag_s2 <= flag_s1;
			fy_s2 <= fy_s1;
			top_s2 <= top_sum[HSW-1:0];
			bottom_s2 <= bottom_sum[HSW-1:0];
		end
	end

	assign wfy = WEIGHT_ONE - {1'b0, fy_s2};
	assign vert_sum = (VSW+1)'(top_s2) * (VSW+1)'(wfy) + (VSW+1)'(bottom_s2) * (VSW+1)'(fy_s2);
	assign blend_pixel = flag_s2 ? '0 : vert_sum[2*WB +: PB];

	assign pop = rsp.valid && rsp.ready;
	assign rsp.valid = count_q != '0;
	assign rsp.pixel_out = fifo_pix_q[rd_ptr_q];
	assign rsp.out_of_range = fifo_flag_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			fifo_pix_q[wr_ptr_q] <= blend_pixel;
			fifo_flag_q[wr_ptr_q] <= flag_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
			inflight_q <= '0;
		end else begin
			if (valid_s2) begin
				wr_ptr_q <= (wr_ptr_q == OPW'(bgis_pkg::OUT_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == OPW'(bgis_pkg::OUT_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (valid_s2 && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !valid_s2) begin
				count_q <= count_q - 1'b1;
			end
			if (launch && !pop) begin
				inflight_q <= inflight_q + 1'b1;
			end else if (pop && !launch) begin
				inflight_q <= inflight_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

/* hdl/bilinear_gray_image_scaler.sv */
// Bilinear scaler for one 8-bit grayscale image held on chip.
// req carries items: opcode 0 writes pixel_in at (column_pos, row_pos) of the source
// store, opcode 1 asks for the destination pixel at (column_pos, row_pos). A write
// yields no beat on rsp; each request yields one rsp beat, in request order, with
// pixel_out and out_of_range (set, pixel_out zero, past the target size).
// cfg writes the size and Q8.16 step registers by index; load it while idle.
// The front stage takes one req beat per cycle while req.ready is high; a two-entry queue sits behind it.
// The back end takes a write or a flagged request in state ST_FIRST and a blended
// request in ST_FIRST then ST_SECOND: the source store is split into even and odd row
// banks, each read once per cycle, so the four neighbors come in as the left column and then the right column.
// A four-entry result buffer lets the back end run ahead while rsp is stalled;
// when it is full, the back end holds, the queue fills and req.ready drops.
// Reset clears the control state and loads the register defaults; the image
// store is not cleared and must be written before it is read.
`default_nettype none
`include "bilinear_gray_image_scaler_assert.svh"
module bilinear_gray_image_scaler #(
	parameter int MAX_WIDTH = bgis_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bgis_pkg::DEF_MAX_HEIGHT,
	parameter int WEIGHT_BITS = bgis_pkg::DEF_WEIGHT_BITS
) (
	input logic clk,
	input logic arst_n,
	bgis_req_if.sink req,
	bgis_rsp_if.source rsp,
	bgis_cfg_if.sink cfg
);
	bgis_cmd_if #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.WEIGHT_BITS(WEIGHT_BITS)
	) cmd_head ();

	bgis_cmd_if #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.WEIGHT_BITS(WEIGHT_BITS)
	) cmd_tail ();

	bgis_front #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.WEIGHT_BITS(WEIGHT_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.cfg(cfg),
		.cmd(cmd_head)
	);

	bgis_queue #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.WEIGHT_BITS(WEIGHT_BITS)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.head(cmd_head),
		.tail(cmd_tail)
	);

	bgis_back #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.WEIGHT_BITS(WEIGHT_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_tail),
		.rsp(rsp)
	);

	`BGIS_ASSERT_IMPLY(a_write_never_waits,
		cmd_tail.valid && cmd_tail.kind == bgis_pkg::CMD_WRITE, cmd_tail.ready)
	`BGIS_ASSERT_IMPLY(a_flagged_pixel_zero,
		rsp.valid && rsp.out_of_range, rsp.pixel_out == '0)
	`BGIS_ASSERT_NEXT(a_blend_two_cycles,
		cmd_tail.valid && cmd_tail.ready && cmd_tail.kind == bgis_pkg::CMD_BLEND,
		!(cmd_tail.valid && cmd_tail.ready && cmd_tail.kind == bgis_pkg::CMD_BLEND))
endmodule
`default_nettype wire
